// ===== rtl/lcs_pkg.sv =====
package lcs_pkg;

  localparam int NUM_SERVERS = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int MASK_BITS   = 16;
  localparam int SLOT_W      = $clog2(NUM_SERVERS);
  localparam int FUNC_W      = 2;
  localparam int IDX_W       = 4;
  localparam int OUT_SRV_W   = 4;
  localparam int OUT_CNT_W   = 16;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [NUM_SERVERS-1:0] slot_vec_t;
  typedef logic [MASK_BITS-1:0]   mask_t;
  typedef logic [FUNC_W-1:0]      func_t;

  // item codes
  localparam func_t FUNC_PICK    = 2'd0;
  localparam func_t FUNC_RELEASE = 2'd1;
  localparam func_t FUNC_CLEAR   = 2'd2;

  localparam count_t CNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_INC       = 2'd1,
    CMD_DEC       = 2'd2,
    CMD_CLEAR_ALL = 2'd3
  } bank_cmd_t;

  // counter bank control: one update per cycle plus a keep-mask load
  typedef struct packed {
    bank_cmd_t cmd;
    slot_t     addr;
    logic      keep_load;
    slot_vec_t keep;
  } bank_ctl_t;

  // slots beyond the mask width are never enabled
  function automatic slot_vec_t enable_vec(mask_t m);
    slot_vec_t v;
    v = '0;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      if (i < MASK_BITS) begin
        v[i] = m[i];
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/lcs_counter_bank.sv =====
module lcs_counter_bank (
  input  logic               clk,
  input  logic               rst,
  input  lcs_pkg::bank_ctl_t ctl,
  input  lcs_pkg::slot_t     rd_addr,
  output lcs_pkg::count_t    rd_data
);

  lcs_pkg::count_t counts [lcs_pkg::NUM_SERVERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lcs_pkg::NUM_SERVERS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      for (int i = 0; i < lcs_pkg::NUM_SERVERS; i++) begin
        if (ctl.keep_load && !ctl.keep[i]) begin
          counts[i] <= '0;
        end else begin
          unique case (ctl.cmd)
            lcs_pkg::CMD_NONE: begin
            end
            lcs_pkg::CMD_INC: begin
              if (ctl.addr == lcs_pkg::SLOT_W'(i) && counts[i] != lcs_pkg::CNT_MAX) begin
                counts[i] <= counts[i] + 1'b1;
              end
            end
            lcs_pkg::CMD_DEC: begin
              if (ctl.addr == lcs_pkg::SLOT_W'(i) && counts[i] != '0) begin
                counts[i] <= counts[i] - 1'b1;
              end
            end
            lcs_pkg::CMD_CLEAR_ALL: begin
              counts[i] <= '0;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign rd_data = counts[rd_addr];

endmodule

// ===== rtl/lcs_scan_unit.sv =====
module lcs_scan_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            step,
  input  logic            slot_en,
  input  lcs_pkg::slot_t  slot,
  input  lcs_pkg::count_t cnt,
  output logic            found,
  output lcs_pkg::slot_t  best,
  output lcs_pkg::count_t best_cnt
);

  logic take;

  // shared compare: strict less keeps the lowest index on a tie
  assign take = step && slot_en && (!found || cnt < best_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best     <= slot;
      best_cnt <= cnt;
    end
  end

endmodule

// ===== rtl/least_connections_selector.sv =====
// Least-connections selector. Holds one saturating connection counter per
// server slot and takes one beat per item: a pick returns the enabled slot
// with the fewest connections (lowest index on a tie) and its count after
// the increment, or no_server when no slot is enabled; a release drops one
// connection from an enabled slot (never below zero); a clear zeroes all
// counters. Every item gives exactly one result beat. enabled_servers is
// the slot enable mask; writing it zeroes the counters of disabled slots,
// and it must only be written while the block is idle. A pick scans the
// counters through one shared comparator, one slot per cycle, then moves
// to the apply state; release and clear go straight from idle to apply.
// The result sits in an output register, so a new item can be accepted
// while the last result waits.
module least_connections_selector (
  input  logic        clk,
  input  logic        rst,
  // enable-mask write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] enabled_servers,
  // item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [3:0]  server_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  chosen_server,
  output logic        no_server,
  output logic [15:0] chosen_count
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t              state, state_next;
  lcs_pkg::mask_t      mask;
  lcs_pkg::slot_vec_t  en_v;
  lcs_pkg::func_t      func_q;
  logic [lcs_pkg::IDX_W-1:0] idx_q;
  lcs_pkg::slot_t      scan_idx;
  lcs_pkg::slot_t      rel_slot;
  logic                rel_ok;
  logic                accept;
  logic                cfg_fire;
  logic                out_free;
  logic                apply_fire;
  logic                scan_last;
  logic                is_pick;
  lcs_pkg::bank_ctl_t  bank_ctl;
  lcs_pkg::count_t     rd_data;
  logic                found;
  lcs_pkg::slot_t      best;
  lcs_pkg::count_t     best_cnt;
  lcs_pkg::count_t     inc_cnt;

  // mask writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cfg_fire) begin
      mask <= lcs_pkg::MASK_BITS'(enabled_servers);
    end
  end

  assign en_v = lcs_pkg::enable_vec(mask);

  // input side: one item in flight
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      idx_q  <= server_index;
    end
  end

  assign is_pick   = (func_q == lcs_pkg::FUNC_PICK);
  assign scan_last = (scan_idx == lcs_pkg::SLOT_W'(lcs_pkg::NUM_SERVERS - 1));

  // release target; out-of-range indexes are ignored
  assign rel_slot = lcs_pkg::SLOT_W'(idx_q);
  assign rel_ok   = (int'(idx_q) < lcs_pkg::NUM_SERVERS) && en_v[rel_slot];

  // output register frees when empty or being drained this cycle
  assign out_free   = !out_valid || !out_stall;
  assign apply_fire = (state == ST_APPLY) && out_free;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (func == lcs_pkg::FUNC_PICK) ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (accept) begin
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // counters are read one slot per scan cycle
  lcs_counter_bank u_bank (
    .clk     (clk),
    .rst     (rst),
    .ctl     (bank_ctl),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  lcs_scan_unit u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .step     (state == ST_SCAN),
    .slot_en  (en_v[scan_idx]),
    .slot     (scan_idx),
    .cnt      (rd_data),
    .found    (found),
    .best     (best),
    .best_cnt (best_cnt)
  );

  // count the picked slot shows after its saturating increment
  assign inc_cnt = (best_cnt == lcs_pkg::CNT_MAX) ? best_cnt : best_cnt + 1'b1;

  // counter updates happen once, when the result beat is loaded
  always_comb begin
    bank_ctl           = '0;
    bank_ctl.cmd       = lcs_pkg::CMD_NONE;
    bank_ctl.addr      = is_pick ? best : rel_slot;
    bank_ctl.keep_load = cfg_fire;
    bank_ctl.keep      = lcs_pkg::enable_vec(lcs_pkg::MASK_BITS'(enabled_servers));
    if (apply_fire) begin
      unique case (func_q)
        lcs_pkg::FUNC_PICK: begin
          if (found) begin
            bank_ctl.cmd = lcs_pkg::CMD_INC;
          end
        end
        lcs_pkg::FUNC_RELEASE: begin
          if (rel_ok) begin
            bank_ctl.cmd = lcs_pkg::CMD_DEC;
          end
        end
        lcs_pkg::FUNC_CLEAR: begin
          bank_ctl.cmd = lcs_pkg::CMD_CLEAR_ALL;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      chosen_server <= (is_pick && found) ? lcs_pkg::OUT_SRV_W'(best) : '0;
      no_server     <= is_pick && !found;
      chosen_count  <= (is_pick && found) ? lcs_pkg::OUT_CNT_W'(inc_cnt) : '0;
    end
  end

endmodule

// ===== bench/least_connections_selector_tb.sv =====
module least_connections_selector_tb;

  // func code 3 has no name in the package; the block ignores it
  localparam lcs_pkg::func_t FUNC_UNUSED = 2'd3;
  localparam int    MAX_GAP     = 10;
  // one slot enabled, picked over and over from a cleared count
  localparam int    FILL_PICKS  = 40;
  localparam int    MAX_LISTED  = 20;
  localparam int    PHASES      = 10;
  localparam int    PHASE_ITEMS = 134;

  // one result beat: what the block should say about one item
  typedef struct packed {
    logic [3:0]  server;
    logic        none;
    logic [15:0] count;
  } selection_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] enabled_servers;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [3:0]  server_index;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  chosen_server;
  logic        no_server;
  logic [15:0] chosen_count;

  least_connections_selector dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .enabled_servers (enabled_servers),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .server_index    (server_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .chosen_server   (chosen_server),
    .no_server       (no_server),
    .chosen_count    (chosen_count)
  );

  // Shadow of the block: per-slot connection counts and the enable mask.
  lcs_pkg::count_t conn_count [lcs_pkg::NUM_SERVERS] = '{default: '0};
  lcs_pkg::mask_t  enable_mask = '0;
  // results still owed by the block, oldest first
  selection_t selection_q [$];

  int err_count   = 0;
  int n_picks     = 0;
  int n_empty     = 0;
  int n_ceiling   = 0;
  int n_releases  = 0;
  int n_clears    = 0;
  int n_unused    = 0;
  int n_mask_wr   = 0;
  int n_results   = 0;

  // when clear, that side runs back to back
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs; about 1400 items are sent in all.
  initial begin
    #3_000_000;
    $display("timeout: results still owed = %0d", selection_q.size());
    $display("simulation failed");
    $finish;
  end

  function automatic bit slot_enabled(input int slot);
    return slot < lcs_pkg::MASK_BITS && enable_mask[slot];
  endfunction

  // Applies one item to the shadow state and returns the beat it should
  // produce. Ties go to the lowest index since only a strictly smaller
  // count replaces the current best.
  function automatic selection_t predict_selection(input lcs_pkg::func_t f,
                                                   input logic [3:0] idx);
    selection_t r;
    bit         found;
    int         best;
    r     = '0;
    found = 1'b0;
    best  = 0;
    case (f)
      lcs_pkg::FUNC_PICK: begin
        for (int i = 0; i < lcs_pkg::NUM_SERVERS; i++) begin
          if (slot_enabled(i) && (!found || conn_count[i] < conn_count[best])) begin
            found = 1'b1;
            best  = i;
          end
        end
        if (!found) begin
          r.none = 1'b1;
        end else begin
          // saturate at the counter ceiling
          if (conn_count[best] != lcs_pkg::CNT_MAX) begin
            conn_count[best]++;
          end
          r.server = best[3:0];
          r.count  = conn_count[best];
        end
      end
      lcs_pkg::FUNC_RELEASE: begin
        // disabled slots are ignored, zero counts stay at zero
        if (slot_enabled(idx) && conn_count[idx] != '0) begin
          conn_count[idx]--;
        end
      end
      lcs_pkg::FUNC_CLEAR: begin
        foreach (conn_count[i]) conn_count[i] = '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_LISTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Sends one item beat. valid is left high after the accept so that a
  // back-to-back item needs no drop; anything that is not another item
  // must go through wait_for_idle, which lowers it.
  task automatic send_item(input lcs_pkg::func_t f, input logic [3:0] idx);
    int         gap;
    selection_t want;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    server_index <= idx;
    do @(posedge clk); while (in_stall);
    want = predict_selection(f, idx);
    selection_q = {selection_q, want};
    case (f)
      lcs_pkg::FUNC_PICK: begin
        n_picks++;
        if (want.none) n_empty++;
        else if (want.count == lcs_pkg::CNT_MAX) n_ceiling++;
      end
      lcs_pkg::FUNC_RELEASE: n_releases++;
      lcs_pkg::FUNC_CLEAR:   n_clears++;
      default:               n_unused++;
    endcase
  endtask

  // Sender holds off until every owed result has been taken.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (selection_q.size() != 0) @(posedge clk);
  endtask

  // Mask writes only happen with nothing in flight; the shadow drops the
  // counts of slots that just lost their enable bit.
  task automatic write_enable_mask(input lcs_pkg::mask_t m);
    wait_for_idle();
    cfg_valid       <= 1'b1;
    enabled_servers <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    enable_mask  = m;
    foreach (conn_count[i]) begin
      if (!slot_enabled(i)) conn_count[i] = '0;
    end
    n_mask_wr++;
  endtask

  // Receiver: a fresh stall stretch before every result beat.
  initial begin
    int gap;
    forever begin
      gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker: every accepted beat against the oldest expectation.
  always @(posedge clk) begin : check_results
    selection_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (selection_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat server=%0d none=%0b count=%0d",
                                  chosen_server, no_server, chosen_count));
      end else begin
        want = selection_q.pop_front();
        if (chosen_server !== want.server) begin
          report_mismatch($sformatf("chosen_server %0d, want %0d", chosen_server, want.server));
        end
        if (no_server !== want.none) begin
          report_mismatch($sformatf("no_server %0b, want %0b", no_server, want.none));
        end
        if (chosen_count !== want.count) begin
          report_mismatch($sformatf("chosen_count %0d, want %0d", chosen_count, want.count));
        end
      end
    end
  end

  // Nothing attached after reset: picks fail, releases fall on disabled
  // slots, clear and the unused code still give an all-zero beat.
  task automatic test_empty_mask();
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    send_item(lcs_pkg::FUNC_RELEASE, 4'd0);
    send_item(lcs_pkg::FUNC_RELEASE, 4'd15);
    send_item(lcs_pkg::FUNC_CLEAR, 4'd9);
    send_item(FUNC_UNUSED, 4'd15);
    wait_for_idle();
  endtask

  // All slots on: lowest index wins ties, a release makes a slot the
  // minimum again, and releasing an idle slot leaves it at zero.
  task automatic test_tie_order();
    write_enable_mask(16'hFFFF);
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    send_item(lcs_pkg::FUNC_PICK, 4'd15);
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    send_item(lcs_pkg::FUNC_RELEASE, 4'd1);
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    send_item(lcs_pkg::FUNC_RELEASE, 4'd5);
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    wait_for_idle();
  endtask

  // Rewriting the mask with live counts: dropped slots lose their count,
  // the outer slots alternate, releases to dropped slots do nothing.
  task automatic test_mask_rewrite();
    write_enable_mask(16'h8001);
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    send_item(lcs_pkg::FUNC_RELEASE, 4'd3);
    send_item(lcs_pkg::FUNC_RELEASE, 4'd0);
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    write_enable_mask(16'h8000);
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    send_item(lcs_pkg::FUNC_RELEASE, 4'd0);
    wait_for_idle();
  endtask

  // Single slot picked back to back so its count climbs by one per beat;
  // the index field of a pick is ignored, and a release then a pick must
  // walk back to the same count.
  task automatic test_single_slot_run();
    write_enable_mask(16'h0001);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_item(lcs_pkg::FUNC_CLEAR, 4'd0);
    for (int i = 0; i < FILL_PICKS; i++) begin
      send_item(lcs_pkg::FUNC_PICK, 4'($urandom_range(0, 15)));
    end
    send_item(lcs_pkg::FUNC_RELEASE, 4'd0);
    send_item(lcs_pkg::FUNC_PICK, 4'd0);
    send_item(lcs_pkg::FUNC_CLEAR, 4'd0);
    wait_for_idle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Random mixes under a sequence of masks; counts carry over between
  // phases so a mask write also clears the live counters of the slots it disables. Every third
  // phase runs without idling, and one phase drains halfway through.
  task automatic test_random_traffic();
    lcs_pkg::mask_t m;
    int             r;
    lcs_pkg::func_t f;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       m = 16'hFFFF;
        1:       m = 16'h0000;
        2:       m = 16'h0001;
        3:       m = 16'h8000;
        4:       m = lcs_pkg::mask_t'(1) << $urandom_range(0, lcs_pkg::MASK_BITS - 1);
        default: m = lcs_pkg::mask_t'($urandom);
      endcase
      write_enable_mask(m);
      tx_idle_on = (p % 3) != 2;
      rx_idle_on = (p % 3) != 2;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) wait_for_idle();
        r = $urandom_range(0, 99);
        if (r < 50)      f = lcs_pkg::FUNC_PICK;
        else if (r < 88) f = lcs_pkg::FUNC_RELEASE;
        else if (r < 94) f = lcs_pkg::FUNC_CLEAR;
        else             f = FUNC_UNUSED;
        send_item(f, 4'($urandom_range(0, 15)));
      end
    end
    wait_for_idle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_valid       <= 1'b0;
    enabled_servers <= '0;
    in_valid        <= 1'b0;
    func            <= lcs_pkg::FUNC_PICK;
    server_index    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_mask();
    test_tie_order();
    test_mask_rewrite();
    test_single_slot_run();
    test_random_traffic();

    // give stray beats time to show after the last pick scan
    wait_for_idle();
    repeat (lcs_pkg::NUM_SERVERS + 4) @(posedge clk);

    $display("covered: %0d picks (%0d with no slot, %0d at the ceiling), %0d releases,",
             n_picks, n_empty, n_ceiling, n_releases);
    $display("  %0d clears, %0d unused codes, %0d mask writes; %0d beats checked, %0d errors",
             n_clears, n_unused, n_mask_wr, n_results, err_count);
    if (err_count == 0 && selection_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lcs_pkg.sv
rtl/lcs_counter_bank.sv
rtl/lcs_scan_unit.sv
rtl/least_connections_selector.sv
bench/least_connections_selector_tb.sv
